// File: src/bed_pkg.sv
// shared constants for the binary edge detector
// no dependencies; used by binary_edge_detector_top and bed_checker
`default_nettype none

package bed_pkg;

	// register port
	localparam int unsigned CFG_W     = 12;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// default size limits
	localparam int unsigned MAX_WIDTH_DEF  = 2048;
	localparam int unsigned MAX_HEIGHT_DEF = 2048;

	// pixel and result fields
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned COL_OUT_W = 11;
	localparam int unsigned ROW_OUT_W = 11;
	localparam int unsigned VAL_W     = 8;

	// floor(sum/3) > 128 is the same as sum >= 3*129
	localparam int unsigned SUM_W     = 10;
	localparam int unsigned BIN_LEVEL = 128;
	localparam logic [SUM_W-1:0] BIN_THRESH = SUM_W'(3 * (BIN_LEVEL + 1));

	localparam logic [VAL_W-1:0] EDGE_VAL = 8'd0;
	localparam logic [VAL_W-1:0] FLAT_VAL = 8'd255;

endpackage

`default_nettype wire

// File: src/bed_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module bed_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read-before-write on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/binary_edge_detector_top.sv
// binary edge detector: threshold, one-bit line buffer and neighbour compare
// depends on bed_pkg and bed_ram
// path: a pixel beat passes the stage-1 register and then the output register
// throughput: one pixel per cycle unless the output is stalled; in the last row each pixel
// yields two results, so the single output register there holds off the next pixel until both are out
// line buffer: one write (this column) and one read (next column) per pixel
// reset: counters to zero, frame size to 640 x 480, line buffer not cleared
`default_nettype none

module binary_edge_detector_top #(
	parameter int unsigned MAX_WIDTH  = bed_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = bed_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           cfg_we,
	input  wire logic [bed_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bed_pkg::CFG_W-1:0]      cfg_data,

	input  wire logic                           pixel_valid,
	output logic                                pixel_ready,
	input  wire logic [bed_pkg::CHAN_W-1:0]     red,
	input  wire logic [bed_pkg::CHAN_W-1:0]     green,
	input  wire logic [bed_pkg::CHAN_W-1:0]     blue,

	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic      [bed_pkg::COL_OUT_W-1:0]  out_column,
	output logic      [bed_pkg::ROW_OUT_W-1:0]  out_row,
	output logic      [bed_pkg::VAL_W-1:0]      edge_value,
	output logic                                last
);

	localparam int unsigned CW  = $clog2(MAX_WIDTH);
	localparam int unsigned RW  = $clog2(MAX_HEIGHT);
	localparam int unsigned WSW = (bed_pkg::CFG_W > $clog2(MAX_WIDTH + 1)) ?
		bed_pkg::CFG_W : $clog2(MAX_WIDTH + 1);
	localparam int unsigned HSW = (bed_pkg::CFG_W > $clog2(MAX_HEIGHT + 1)) ?
		bed_pkg::CFG_W : $clog2(MAX_HEIGHT + 1);

	// configuration
	logic [bed_pkg::CFG_W-1:0] frame_width_q;
	logic [bed_pkg::CFG_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= bed_pkg::FRAME_WIDTH_RST;
			frame_height_q <= bed_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bed_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				bed_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp sizes to 1..max
	logic [WSW-1:0] width_ext, width_lim;
	logic [HSW-1:0] height_ext, height_lim;

	always_comb begin
		width_ext  = WSW'(frame_width_q);
		height_ext = HSW'(frame_height_q);
		if (width_ext == '0)
			width_lim = WSW'(1);
		else if (width_ext > WSW'(MAX_WIDTH))
			width_lim = WSW'(MAX_WIDTH);
		else
			width_lim = width_ext;
		if (height_ext == '0)
			height_lim = HSW'(1);
		else if (height_ext > HSW'(MAX_HEIGHT))
			height_lim = HSW'(MAX_HEIGHT);
		else
			height_lim = height_ext;
	end

	// position counters
	logic [CW-1:0] col_q, col_nxt;
	logic [RW-1:0] row_q, row_nxt;
	logic          last_col, last_row, below_height;

	always_comb begin
		last_col     = (WSW'(col_q) + WSW'(1)) >= width_lim;
		last_row     = (HSW'(row_q) + HSW'(1)) >= height_lim;
		below_height = HSW'(row_q) < height_lim;
		if (last_col) begin
			col_nxt = '0;
			row_nxt = last_row ? '0 : row_q + RW'(1);
		end else begin
			col_nxt = col_q + CW'(1);
			row_nxt = row_q;
		end
	end

	// binarise the incoming pixel
	logic [bed_pkg::SUM_W-1:0] sum;
	logic                      cur;

	assign sum = bed_pkg::SUM_W'(red) + bed_pkg::SUM_W'(green) + bed_pkg::SUM_W'(blue);
	assign cur = sum >= bed_pkg::BIN_THRESH;

	// stage 1 and handshake
	logic          valid_s1, has_up_s1, has_low_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          cur_s1, above_s1, cmp_ok_s1;
	logic          result_valid_q;
	logic          accept, out_free, emit, s1_done;
	logic          ram_rdata;
	logic          fwd_q, fwd_bit_q, line_rd;

	assign accept   = pixel_valid && pixel_ready;
	assign out_free = !result_valid_q || result_ready;
	assign emit     = valid_s1 && (has_up_s1 || has_low_s1) && out_free;
	assign s1_done  = valid_s1 && (!(has_up_s1 || has_low_s1) ||
		(out_free && !(has_up_s1 && has_low_s1)));
	assign pixel_ready = !valid_s1 || s1_done;

	// read and write of the same entry in one cycle: the ram gives the old bit,
	// so take the bit just written instead
	assign line_rd = fwd_q ? fwd_bit_q : ram_rdata;

	// write this column, read the next one; the read is the right neighbour
	// now and becomes the upper neighbour of the following pixel
	bed_ram #(
		.WIDTH (1),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (cur),
		.re    (accept),
		.raddr (col_nxt),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			valid_s1   <= 1'b0;
			has_up_s1  <= 1'b0;
			has_low_s1 <= 1'b0;
			fwd_q      <= 1'b0;
		end else if (accept) begin
			col_q      <= col_nxt;
			row_q      <= row_nxt;
			valid_s1   <= 1'b1;
			has_up_s1  <= row_q != '0;
			has_low_s1 <= last_row;
			fwd_q      <= col_nxt == col_q;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			// upper result went out, lower one still to go
			has_up_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= col_q;
			row_s1    <= row_q;
			cur_s1    <= cur;
			above_s1  <= line_rd;
			cmp_ok_s1 <= !last_col && below_height;
			fwd_bit_q <= cur;
		end
	end

	logic [bed_pkg::VAL_W-1:0] up_val;

	assign up_val = (cmp_ok_s1 && above_s1 == line_rd && above_s1 == cur_s1) ?
		bed_pkg::FLAT_VAL : bed_pkg::EDGE_VAL;

	// output register
	logic [bed_pkg::COL_OUT_W-1:0] out_column_q;
	logic [bed_pkg::ROW_OUT_W-1:0] out_row_q;
	logic [bed_pkg::VAL_W-1:0]     edge_value_q;
	logic                          last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_column_q <= bed_pkg::COL_OUT_W'(col_s1);
			if (has_up_s1) begin
				out_row_q    <= bed_pkg::ROW_OUT_W'(row_s1 - RW'(1));
				edge_value_q <= up_val;
			end else begin
				out_row_q    <= bed_pkg::ROW_OUT_W'(row_s1);
				edge_value_q <= bed_pkg::EDGE_VAL;
			end
			last_q <= !(has_up_s1 && has_low_s1);
		end
	end

	assign result_valid = result_valid_q;
	assign out_column   = out_column_q;
	assign out_row      = out_row_q;
	assign edge_value   = edge_value_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// File: src/bed_checker.sv
// port-level checks for the binary edge detector, bound to the top level
// depends on bed_pkg and binary_edge_detector_top
`default_nettype none

module bed_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           result_valid,
	input wire logic                           result_ready,
	input wire logic [bed_pkg::COL_OUT_W-1:0]  out_column,
	input wire logic [bed_pkg::ROW_OUT_W-1:0]  out_row,
	input wire logic [bed_pkg::VAL_W-1:0]      edge_value,
	input wire logic                           last
);

	localparam int unsigned ROW_W = bed_pkg::ROW_OUT_W;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(out_column) && $stable(out_row) &&
			$stable(edge_value) && $stable(last))
		else $error("result beat changed while stalled");

	// only black or white comes out
	a_val_set: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (edge_value == bed_pkg::EDGE_VAL ||
			edge_value == bed_pkg::FLAT_VAL))
		else $error("edge value neither black nor white");

	// the second result of a pixel follows at once
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last |=> result_valid && last)
		else $error("second result of a pixel missing");

	// second result is the same column one row down, always black
	a_pair_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last |=>
			out_column == $past(out_column) &&
			out_row == ROW_W'($past(out_row) + 1'b1) &&
			edge_value == bed_pkg::EDGE_VAL)
		else $error("second result at wrong place or not black");

endmodule

bind binary_edge_detector_top bed_checker u_bed_checker (.*);

`default_nettype wire
